// ===== hw/rtl/wbs_pkg.sv =====
// ----------------------------------------------------------------------------
// wbs_pkg
// Shared types, constants and the control program of the weekly bell scheduler.
// ----------------------------------------------------------------------------
package wbs_pkg;

	localparam int MAX_ALARMS = 30;
	localparam int DAYS       = 7;
	localparam int BELL_LIMIT = 99;
	localparam int TPS_RESET  = 1000;

	localparam int SLOT_W     = 5;
	localparam int DAY_W      = 3;
	localparam int HOUR_W     = 5;
	localparam int MIN_W      = 6;
	localparam int TIME_W     = HOUR_W + MIN_W;
	localparam int SEC_W      = 7;
	localparam int TICK_W     = 10;
	localparam int DAY_N      = 1 << DAY_W;
	localparam int RAM_DEPTH  = DAY_N << SLOT_W;
	localparam int RAM_AW     = DAY_W + SLOT_W;
	localparam int XCNT_W     = SLOT_W + 1;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;

	localparam logic [CFG_IDX_W-1:0] CFG_BELL_SECONDS     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LAST_WEEKDAY     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SECOND = 2'd2;

	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_READ  = 2'd1;
	localparam logic [1:0] ACT_STORE = 2'd2;

	typedef struct packed {
		logic [1:0]        action;
		logic [HOUR_W-1:0] hour;
		logic [MIN_W-1:0]  minute;
		logic [5:0]        second;
		logic [DAY_W-1:0]  weekday;
		logic [SLOT_W-1:0] slot;
	} in_item_t;

	typedef struct packed {
		logic              bell_on;
		logic [SEC_W-1:0]  seconds_left;
		logic [HOUR_W-1:0] next_hour;
		logic [MIN_W-1:0]  next_minute;
		logic              no_next_bell;
		logic              bell_started;
	} out_item_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_FETCH,
		OP_TICK,
		OP_READ_INIT,
		OP_SCAN_RD,
		OP_HIT,
		OP_LOAD_NEXT,
		OP_STORE_INIT,
		OP_STORE_WR,
		OP_EMIT
	} op_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_TAKE,
		C_ACT_TICK,
		C_ACT_READ,
		C_ACT_STORE,
		C_READ_SKIP,
		C_X_GT_CNT,
		C_NO_HIT,
		C_STORE_SKIP,
		C_D_LT_LAST,
		C_OUT_BUSY
	} cond_t;

	localparam int PC_W = 4;
	typedef logic [PC_W-1:0] pc_t;

	localparam pc_t S_FETCH   = 4'd0;
	localparam pc_t S_DISP0   = 4'd1;
	localparam pc_t S_DISP1   = 4'd2;
	localparam pc_t S_DISP2   = 4'd3;
	localparam pc_t S_UNUSED  = 4'd4;
	localparam pc_t S_TICK    = 4'd5;
	localparam pc_t S_READ    = 4'd6;
	localparam pc_t S_SCAN    = 4'd7;
	localparam pc_t S_TEST    = 4'd8;
	localparam pc_t S_HIT     = 4'd9;
	localparam pc_t S_NEXT    = 4'd10;
	localparam pc_t S_STORE   = 4'd11;
	localparam pc_t S_STLOOP  = 4'd12;
	localparam pc_t S_EMIT    = 4'd13;
	localparam pc_t S_LAST    = S_EMIT;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   target;
	} ctrl_word_t;

	typedef struct packed {
		logic       take;
		logic [1:0] action;
		logic       read_skip;
		logic       x_gt_cnt;
		logic       hit;
		logic       store_skip;
		logic       d_lt_last;
		logic       out_busy;
	} status_t;

	function automatic ctrl_word_t ucode(input pc_t pc);
		ctrl_word_t w;
		unique case (pc)
			S_FETCH:  w = '{OP_FETCH,      C_NO_TAKE,    S_FETCH};
			S_DISP0:  w = '{OP_NOP,        C_ACT_TICK,   S_TICK};
			S_DISP1:  w = '{OP_NOP,        C_ACT_READ,   S_READ};
			S_DISP2:  w = '{OP_NOP,        C_ACT_STORE,  S_STORE};
			S_UNUSED: w = '{OP_NOP,        C_ALWAYS,     S_EMIT};
			S_TICK:   w = '{OP_TICK,       C_ALWAYS,     S_EMIT};
			S_READ:   w = '{OP_READ_INIT,  C_READ_SKIP,  S_EMIT};
			S_SCAN:   w = '{OP_SCAN_RD,    C_X_GT_CNT,   S_EMIT};
			S_TEST:   w = '{OP_NOP,        C_NO_HIT,     S_SCAN};
			S_HIT:    w = '{OP_HIT,        C_X_GT_CNT,   S_EMIT};
			S_NEXT:   w = '{OP_LOAD_NEXT,  C_ALWAYS,     S_EMIT};
			S_STORE:  w = '{OP_STORE_INIT, C_STORE_SKIP, S_EMIT};
			S_STLOOP: w = '{OP_STORE_WR,   C_D_LT_LAST,  S_STLOOP};
			S_EMIT:   w = '{OP_EMIT,       C_OUT_BUSY,   S_EMIT};
			default:  w = '{OP_NOP,        C_ALWAYS,     S_FETCH};
		endcase
		return w;
	endfunction

endpackage

// ===== hw/rtl/wbs_ram.sv =====
// ----------------------------------------------------------------------------
// wbs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module wbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/wbs_seq.sv =====
// ----------------------------------------------------------------------------
// wbs_seq
// Microcode sequencer: step counter, control ROM and conditional jumps.
// ----------------------------------------------------------------------------
module wbs_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  wbs_pkg::status_t    stat,
	output wbs_pkg::ctrl_word_t ctrl
);
	import wbs_pkg::*;

	pc_t  pc_q;
	pc_t  pc_d;
	logic jump;

	assign ctrl = ucode(pc_q);

	always_comb begin
		unique case (ctrl.cond)
			C_NEVER:      jump = 1'b0;
			C_ALWAYS:     jump = 1'b1;
			C_NO_TAKE:    jump = !stat.take;
			C_ACT_TICK:   jump = stat.action == ACT_TICK;
			C_ACT_READ:   jump = stat.action == ACT_READ;
			C_ACT_STORE:  jump = stat.action == ACT_STORE;
			C_READ_SKIP:  jump = stat.read_skip;
			C_X_GT_CNT:   jump = stat.x_gt_cnt;
			C_NO_HIT:     jump = !stat.hit;
			C_STORE_SKIP: jump = stat.store_skip;
			C_D_LT_LAST:  jump = stat.d_lt_last;
			C_OUT_BUSY:   jump = stat.out_busy;
			default:      jump = 1'b0;
		endcase
	end

	always_comb begin
		if (jump) begin
			pc_d = ctrl.target;
		end else if (pc_q == S_LAST) begin
			pc_d = S_FETCH;
		end else begin
			pc_d = pc_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_FETCH;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule

// ===== hw/rtl/wbs_dp.sv =====
// ----------------------------------------------------------------------------
// wbs_dp
// Datapath: alarm table, per-day counts, bell countdown, config and result register.
// ----------------------------------------------------------------------------
module wbs_dp #(
	parameter int MAX_ALARMS = wbs_pkg::MAX_ALARMS,
	parameter int DAYS       = wbs_pkg::DAYS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  wbs_pkg::ctrl_word_t                ctrl,
	output wbs_pkg::status_t                   stat,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  wbs_pkg::in_item_t                  in_item,
	output logic                               out_valid,
	input  logic                               out_stall,
	output wbs_pkg::out_item_t                 out_item,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [wbs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [wbs_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import wbs_pkg::*;

	// table clear after reset
	logic              clr_q;
	logic [RAM_AW-1:0] clr_addr_q;

	// configuration
	logic [SEC_W-1:0]  bell_q;
	logic [DAY_W-1:0]  lastwd_q;
	logic [TICK_W-1:0] tps_q;

	// scheduler state
	logic [SLOT_W-1:0] counts_q [DAY_N];
	logic [TICK_W-1:0] tick_q;
	logic [SEC_W-1:0]  ring_q;
	logic              ringing_q;
	logic              mc_q;
	logic [TIME_W-1:0] next_q;
	logic              final_q;
	logic              started_q;

	// per-item working registers
	in_item_t          item_q;
	logic [XCNT_W-1:0] x_q;
	logic [SLOT_W-1:0] cnt_q;
	logic [DAY_W-1:0]  d_q;
	logic [DAY_W-1:0]  last_q;
	out_item_t         out_q;
	logic              out_valid_q;

	logic              take;
	logic              emit;
	logic              out_busy;
	logic [TIME_W-1:0] now;
	logic              day_ok;
	logic [SLOT_W-1:0] cnt_raw;
	logic [SLOT_W-1:0] cnt_lim;
	logic              x_gt_cnt;
	logic              d_le_last;
	logic [TICK_W-1:0] tick_inc;
	logic [TICK_W-1:0] tps_eff;
	logic              sec_done;
	logic [SEC_W-1:0]  bell_sat;
	logic [DAY_W-1:0]  lw_lim;

	logic              ram_we;
	logic [RAM_AW-1:0] ram_waddr;
	logic [TIME_W-1:0] ram_wdata;
	logic [RAM_AW-1:0] ram_raddr;
	logic [TIME_W-1:0] ram_rdata;

	assign in_stall  = !(ctrl.op == OP_FETCH && !clr_q);
	assign take      = in_valid && !in_stall;
	assign out_busy  = out_valid_q && out_stall;
	assign emit      = ctrl.op == OP_EMIT && !out_busy;
	assign cfg_ready = 1'b1;

	assign now       = {item_q.hour, item_q.minute};
	assign day_ok    = item_q.weekday != '0 && item_q.weekday <= DAY_W'(DAYS);
	assign cnt_raw   = counts_q[item_q.weekday];
	assign cnt_lim   = (cnt_raw > SLOT_W'(MAX_ALARMS)) ? SLOT_W'(MAX_ALARMS) : cnt_raw;
	assign x_gt_cnt  = x_q > {1'b0, cnt_q};
	assign d_le_last = d_q <= last_q;
	assign tick_inc  = tick_q + 1'b1;
	assign tps_eff   = (tps_q == '0) ? TICK_W'(1) : tps_q;
	assign sec_done  = tick_inc >= tps_eff;
	assign bell_sat  = (bell_q > SEC_W'(BELL_LIMIT)) ? SEC_W'(BELL_LIMIT) : bell_q;
	assign lw_lim    = (lastwd_q > DAY_W'(DAYS)) ? DAY_W'(DAYS) : lastwd_q;

	always_comb begin
		stat.take       = take;
		stat.action     = item_q.action;
		stat.read_skip  = item_q.second != '0 || mc_q || !day_ok;
		stat.x_gt_cnt   = x_gt_cnt;
		stat.hit        = ram_rdata == now;
		stat.store_skip = item_q.slot == '0 || item_q.slot > SLOT_W'(MAX_ALARMS)
			|| item_q.weekday > DAY_W'(DAYS);
		stat.d_lt_last  = d_q < last_q;
		stat.out_busy   = out_busy;
	end

	always_comb begin
		ram_we    = clr_q || (ctrl.op == OP_STORE_WR && d_le_last);
		ram_waddr = clr_q ? clr_addr_q : {d_q, item_q.slot};
		ram_wdata = clr_q ? '0 : now;
		ram_raddr = {item_q.weekday, x_q[SLOT_W-1:0]};
	end

	wbs_ram #(
		.WIDTH (TIME_W),
		.DEPTH (RAM_DEPTH)
	) u_times (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == RAM_AW'(RAM_DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bell_q   <= '0;
			lastwd_q <= '0;
			tps_q    <= TICK_W'(TPS_RESET);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_BELL_SECONDS:     bell_q   <= cfg_data[SEC_W-1:0];
				CFG_LAST_WEEKDAY:     lastwd_q <= cfg_data[DAY_W-1:0];
				CFG_TICKS_PER_SECOND: tps_q    <= cfg_data[TICK_W-1:0];
				default:              ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DAY_N; i++) begin
				counts_q[i] <= '0;
			end
			tick_q    <= '0;
			ring_q    <= '0;
			ringing_q <= 1'b0;
			mc_q      <= 1'b0;
			next_q    <= '0;
			final_q   <= 1'b1;
			started_q <= 1'b0;
		end else begin
			case (ctrl.op)
				OP_FETCH: begin
					if (take) begin
						started_q <= 1'b0;
					end
				end
				OP_TICK: begin
					if (ringing_q) begin
						if (sec_done) begin
							tick_q <= '0;
							if (ring_q <= SEC_W'(1)) begin
								ring_q    <= '0;
								ringing_q <= 1'b0;
							end else begin
								ring_q <= ring_q - 1'b1;
							end
						end else begin
							tick_q <= tick_inc;
						end
					end
				end
				OP_READ_INIT: mc_q <= item_q.second == '0;
				OP_HIT: begin
					ring_q    <= bell_sat;
					ringing_q <= 1'b1;
					started_q <= 1'b1;
					final_q   <= x_gt_cnt;
				end
				OP_LOAD_NEXT: begin
					next_q  <= ram_rdata;
					final_q <= 1'b0;
				end
				OP_STORE_WR: begin
					if (d_le_last) begin
						counts_q[d_q] <= item_q.slot;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_FETCH: begin
				if (take) begin
					item_q <= in_item;
				end
			end
			OP_READ_INIT: begin
				x_q   <= XCNT_W'(1);
				cnt_q <= cnt_lim;
			end
			OP_SCAN_RD: x_q <= x_q + 1'b1;
			OP_STORE_INIT: begin
				if (item_q.weekday == '0) begin
					d_q    <= DAY_W'(1);
					last_q <= lw_lim;
				end else begin
					d_q    <= item_q.weekday;
					last_q <= item_q.weekday;
				end
			end
			OP_STORE_WR: d_q <= d_q + 1'b1;
			default: ;
		endcase
		if (emit) begin
			out_q.bell_on      <= ringing_q;
			out_q.seconds_left <= ring_q;
			out_q.next_hour    <= final_q ? '0 : next_q[TIME_W-1:MIN_W];
			out_q.next_minute  <= final_q ? '0 : next_q[MIN_W-1:0];
			out_q.no_next_bell <= final_q;
			out_q.bell_started <= started_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

// ===== hw/rtl/weekly_bell_scheduler.sv =====
// ----------------------------------------------------------------------------
// weekly_bell_scheduler
// Per-weekday bell time table with once-a-minute match and ringing countdown.
//
// Input channel (in_valid/in_stall/in_item) takes ticks, clock readings and
// slot stores; every item yields exactly one result on the output channel
// (out_valid/out_stall/out_item). Config writes go on cfg_valid/cfg_index/
// cfg_data; cfg_ready is always high.
// A microcoded step counter runs each item: fetch, dispatch, then a tick
// step; for an unused action a step that jumps to emit; for a store a setup
// step and, unless it is ignored, a write loop over the days; for a clock
// reading a setup step and, unless it is not evaluated, a read-and-test loop
// over the day's slots, a hit step and, if a later slot exists, a load of it.
// Every path ends at the emit step. The next item is taken at the first edge
// at which the result can be taken, once the current one has reached the
// output register. If out_stall holds, that result waits there; the next
// item is still worked, then the sequencer holds at emit with in_stall high.
// After reset the alarm table is cleared one entry per cycle; in_stall
// stays high while the clear runs, and config writes are still taken.
// ----------------------------------------------------------------------------
module weekly_bell_scheduler #(
	parameter int MAX_ALARMS = wbs_pkg::MAX_ALARMS,
	parameter int DAYS       = wbs_pkg::DAYS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  wbs_pkg::in_item_t              in_item,
	output logic                           out_valid,
	input  logic                           out_stall,
	output wbs_pkg::out_item_t             out_item,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [wbs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wbs_pkg::CFG_DATA_W-1:0] cfg_data
);
	import wbs_pkg::*;

	ctrl_word_t ctrl;
	status_t    stat;

	wbs_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	wbs_dp #(
		.MAX_ALARMS (MAX_ALARMS),
		.DAYS       (DAYS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.stat      (stat),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

`ifndef SYNTHESIS
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.op != OP_FETCH) |-> in_stall)
		else $error("item taken outside fetch step");

	a_quiet_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_item.bell_on) |-> (out_item.seconds_left == '0))
		else $error("seconds left while bell off");

	a_start_on: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.bell_started) |-> out_item.bell_on)
		else $error("bell started but not ringing");
`endif

endmodule

// ===== tb/sv/weekly_bell_scheduler_tb.sv =====
// ----------------------------------------------------------------------------
// weekly_bell_scheduler_tb
// Self-checking bench for the weekly bell scheduler. A behavioral copy of the
// alarm table, minute check and ringing countdown predicts one report per
// accepted item. Directed items hit the corner cases first. Randomized
// traffic then runs under several register settings: schedules built from a
// small pool of times, clock readings against them, tick bursts and noise.
// Receiver stalls are random throughout; sender gaps in all but one phase.
// ----------------------------------------------------------------------------
module weekly_bell_scheduler_tb;
	import wbs_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int QUIET_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 80;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_item;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	weekly_bell_scheduler dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// scheduler image
	logic [TIME_W-1:0] slot_time [RAM_DEPTH];
	logic [SLOT_W-1:0] slot_count [DAY_N];
	logic [TICK_W-1:0] tick_acc;
	logic [SEC_W-1:0]  ring_left;
	bit                ringing_now;
	bit                minute_seen;
	logic [TIME_W-1:0] next_at;
	bit                at_last_slot;
	logic [6:0]        set_bell;
	logic [2:0]        set_lastday;
	logic [9:0]        set_tps;

	out_item_t pending_reports [$];
	int errors = 0;
	int items_sent = 0;
	int starts_seen = 0;
	int last_slot_hits = 0;
	int cfg_writes = 0;
	int drain_pauses = 0;
	int phases = 0;
	int burst_left = 0;
	bit no_gaps = 0;

	task automatic clear_schedule();
		int i;
		for (i = 0; i < RAM_DEPTH; i++)
			slot_time[i] = '0;
		for (i = 0; i < DAY_N; i++)
			slot_count[i] = '0;
		tick_acc = '0;
		ring_left = '0;
		ringing_now = 0;
		minute_seen = 0;
		next_at = '0;
		at_last_slot = 1;
		set_bell = '0;
		set_lastday = '0;
		set_tps = 10'(TPS_RESET);
	endtask

	function automatic out_item_t bell_report(input in_item_t it);
		out_item_t r;
		logic [TIME_W-1:0] now;
		int cnt, last, x, d;
		bit started;
		now = {it.hour, it.minute};
		started = 0;
		case (it.action)
			ACT_TICK: begin
				if (ringing_now) begin
					tick_acc = tick_acc + 1'b1;
					if (tick_acc >= set_tps) begin
						tick_acc = '0;
						if (ring_left <= 1) begin
							ring_left = '0;
							ringing_now = 0;
						end else begin
							ring_left = ring_left - 1'b1;
						end
					end
				end
			end
			ACT_READ: begin
				if (it.second != 0) begin
					minute_seen = 0;
				end else if (!minute_seen) begin
					minute_seen = 1;
					if (it.weekday >= 1 && it.weekday <= DAYS) begin
						cnt = slot_count[it.weekday];
						if (cnt > MAX_ALARMS)
							cnt = MAX_ALARMS;
						for (x = 1; x <= cnt; x++) begin
							if (slot_time[(it.weekday * 32 + x) % RAM_DEPTH] == now) begin
								ring_left = (set_bell > BELL_LIMIT) ? 7'(BELL_LIMIT) : set_bell;
								ringing_now = 1;
								started = 1;
								if (x == cnt) begin
									at_last_slot = 1;
								end else begin
									at_last_slot = 0;
									next_at = slot_time[(it.weekday * 32 + x + 1) % RAM_DEPTH];
								end
								break;
							end
						end
					end
				end
			end
			ACT_STORE: begin
				if (it.slot >= 1 && it.slot <= MAX_ALARMS) begin
					if (it.weekday == 0) begin
						last = (set_lastday > DAYS) ? DAYS : set_lastday;
						for (d = 1; d <= last; d++) begin
							slot_time[(d * 32 + it.slot) % RAM_DEPTH] = now;
							slot_count[d] = it.slot;
						end
					end else if (it.weekday <= DAYS) begin
						slot_time[(it.weekday * 32 + it.slot) % RAM_DEPTH] = now;
						slot_count[it.weekday] = it.slot;
					end
				end
			end
			default: ;
		endcase
		r.bell_on = ringing_now;
		r.seconds_left = ring_left;
		r.next_hour = at_last_slot ? '0 : next_at[TIME_W-1:MIN_W];
		r.next_minute = at_last_slot ? '0 : next_at[MIN_W-1:0];
		r.no_next_bell = at_last_slot;
		r.bell_started = started;
		return r;
	endfunction

	function automatic in_item_t mk(input logic [1:0] act, input logic [4:0] h,
			input logic [5:0] m, input logic [5:0] s, input logic [2:0] d,
			input logic [4:0] sl);
		in_item_t it;
		it.action = act;
		it.hour = h;
		it.minute = m;
		it.second = s;
		it.weekday = d;
		it.slot = sl;
		return it;
	endfunction

	function automatic in_item_t rand_item();
		logic [31:0] raw;
		raw = $urandom;
		return raw[$bits(in_item_t)-1:0];
	endfunction

	task automatic send_item(input in_item_t it);
		int gap;
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (in_stall);
		pending_reports.push_back(bell_report(it));
		items_sent++;
		if (!no_gaps && burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = $urandom_range(1, 16);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else if (burst_left > 0) begin
			burst_left--;
		end
	endtask

	task automatic send_ticks(input int n);
		in_item_t it;
		repeat (n) begin
			it = rand_item();
			it.action = ACT_TICK;
			send_item(it);
		end
	endtask

	task automatic send_store(input logic [2:0] d, input logic [4:0] sl,
			input logic [4:0] h, input logic [5:0] m);
		send_item(mk(ACT_STORE, h, m, 6'($urandom), d, sl));
	endtask

	// re-arm with a nonzero second, then the second-zero reading
	task automatic send_reading(input logic [2:0] d, input logic [4:0] h,
			input logic [5:0] m);
		send_item(mk(ACT_READ, h, m, 6'($urandom_range(1, 63)), d, 5'($urandom)));
		send_item(mk(ACT_READ, h, m, 6'd0, d, 5'($urandom)));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic apply_settings(input int bell, input int lastday, input int tps);
		logic [CFG_IDX_W-1:0] regs [3];
		logic [CFG_DATA_W-1:0] vals [3];
		int i;
		regs[0] = CFG_BELL_SECONDS;
		regs[1] = CFG_LAST_WEEKDAY;
		regs[2] = CFG_TICKS_PER_SECOND;
		vals[0] = CFG_DATA_W'(bell);
		vals[1] = CFG_DATA_W'(lastday);
		vals[2] = CFG_DATA_W'(tps);
		for (i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			case (regs[i])
				CFG_BELL_SECONDS:     set_bell = vals[i][6:0];
				CFG_LAST_WEEKDAY:     set_lastday = vals[i][2:0];
				CFG_TICKS_PER_SECOND: set_tps = vals[i][9:0];
				default: ;
			endcase
			cfg_writes++;
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic test_power_on_defaults();
		in_item_t it;
		send_ticks(1);
		it = rand_item();
		it.action = ACT_UNUSED;
		send_item(it);
		send_item(mk(ACT_READ, 5'd0, 6'd0, 6'd0, 3'd1, 5'd0));
		send_store(3'd0, 5'd1, 5'd7, 6'd15);
		send_store(3'd2, 5'd0, 5'd9, 6'd0);
		send_store(3'd2, 5'd31, 5'd9, 6'd0);
	endtask

	task automatic test_ring_and_countdown();
		drain();
		apply_settings(2, 5, 3);
		send_store(3'd0, 5'd1, 5'd8, 6'd0);
		send_store(3'd3, 5'd2, 5'd8, 6'd30);
		send_store(3'd3, 5'd3, 5'd31, 6'd63);
		send_reading(3'd3, 5'd8, 6'd0);
		send_item(mk(ACT_READ, 5'd8, 6'd0, 6'd0, 3'd3, 5'd0));
		send_ticks(6);
		send_reading(3'd3, 5'd31, 6'd63);
		// retrigger with ticks already counted
		send_ticks(2);
		send_reading(3'd3, 5'd8, 6'd30);
		send_ticks(1);
		send_reading(3'd0, 5'd8, 6'd0);
	endtask

	task automatic test_saturation_and_fast_ticks();
		drain();
		apply_settings(127, 7, 0);
		send_store(3'd0, 5'd30, 5'd23, 6'd59);
		send_reading(3'd7, 5'd23, 6'd59);
		send_ticks(1);
	endtask

	task automatic test_random_traffic(input int bell, input int lastday, input int tps,
			input int n, input bit steady);
		logic [4:0] pool_h [4];
		logic [5:0] pool_m [4];
		in_item_t it;
		int done, r, k, p;
		logic [2:0] d;
		logic [4:0] sl;
		drain();
		apply_settings(bell, lastday, tps);
		phases++;
		no_gaps = steady;
		for (k = 0; k < 4; k++) begin
			pool_h[k] = 5'($urandom_range(0, 23));
			pool_m[k] = 6'($urandom_range(0, 59));
		end
		if ($urandom_range(0, 1)) begin
			pool_h[3] = 5'd31;
			pool_m[3] = 6'd63;
		end
		done = 0;
		while (done < n) begin
			r = $urandom_range(0, 99);
			p = $urandom_range(0, 3);
			if (r < 30) begin
				k = $urandom_range(1, 6);
				send_ticks(k);
				done += k;
			end else if (r < 65) begin
				d = ($urandom_range(0, 9) == 0) ? 3'd0 : 3'($urandom_range(1, 7));
				if ($urandom_range(0, 4) == 0)
					send_reading(d, 5'($urandom), 6'($urandom));
				else
					send_reading(d, pool_h[p], pool_m[p]);
				if ($urandom_range(0, 6) == 0)
					send_item(mk(ACT_READ, pool_h[p], pool_m[p], 6'd0, d, 5'($urandom)));
				done += 2;
			end else if (r < 85) begin
				sl = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(1, 30)) :
					5'($urandom_range(1, 5));
				d = ($urandom_range(0, 2) == 0) ? 3'd0 : 3'($urandom_range(1, 7));
				send_store(d, sl, pool_h[p], pool_m[p]);
				done++;
			end else if (r < 97) begin
				send_item(rand_item());
				done++;
			end else begin
				drain();
				drain_pauses++;
			end
		end
		no_gaps = 0;
	endtask

	// result check
	out_item_t want;
	task automatic check_field(input string name, input logic [6:0] w, input logic [6:0] g);
		if (w !== g) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, w, g);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_reports.size() == 0) begin
				errors++;
				$display("%0t: unexpected item, expected none, actual %p", $time, out_item);
			end else begin
				want = pending_reports.pop_front();
				check_field("bell_on", 7'(want.bell_on), 7'(out_item.bell_on));
				check_field("seconds_left", want.seconds_left, out_item.seconds_left);
				check_field("next_hour", 7'(want.next_hour), 7'(out_item.next_hour));
				check_field("next_minute", 7'(want.next_minute), 7'(out_item.next_minute));
				check_field("no_next_bell", 7'(want.no_next_bell),
					7'(out_item.no_next_bell));
				check_field("bell_started", 7'(want.bell_started),
					7'(out_item.bell_started));
				if (want.bell_started) begin
					starts_seen++;
					if (want.no_next_bell)
						last_slot_hits++;
				end
			end
		end
	end

	// receiver stall pattern
	int stall_mode = 0;
	int mode_left = 0;
	int stall_cnt = 0;
	bit stall_now;
	always @(posedge clk) begin
		if (mode_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			mode_left = $urandom_range(20, 200);
		end else begin
			mode_left--;
		end
		stall_cnt++;
		case (stall_mode)
			0: stall_now = 0;
			1: stall_now = ($urandom_range(0, 3) == 0);
			2: stall_now = ($urandom_range(0, 3) != 0);
			default: stall_now = ((stall_cnt % 48) >= 24);
		endcase
		out_stall <= arst_n ? stall_now : 1'b0;
	end

	int quiet = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("%0t: no handshake for %0d cycles, %0d items pending",
					$time, quiet, pending_reports.size());
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		clear_schedule();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_power_on_defaults();
		test_ring_and_countdown();
		test_saturation_and_fast_ticks();
		test_random_traffic(0, 0, 1, 230, 0);
		test_random_traffic(127, 7, 1000, 230, 1);
		test_random_traffic(3, 7, 2, 230, 0);
		test_random_traffic($urandom_range(0, 99), $urandom_range(0, 7),
			$urandom_range(1, 8), 230, 0);
		test_random_traffic(99, 7, 0, 230, 0);
		test_random_traffic(1, 1, 1, 230, 0);
		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Run covered %0d items over %0d random setting phases and %0d config writes;",
			items_sent, phases, cfg_writes);
		$display("%0d bell starts (%0d on a last slot), %0d pauses for an empty pipeline.",
			starts_seen, last_slot_hits, drain_pauses);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
